### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the hash table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property holds at every clock edge outside reset.
`define DMHT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define DMHT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DMHT_ASSERT(label, clk, rst, prop, msg)
`define DMHT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### hw/rtl/dmht_pkg.sv
// ----------------------------------------------------------------------------
// dmht_pkg
// Types and constants of the depth-preferred direct-mapped hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package dmht_pkg;

   localparam int KEY_W   = 64;
   localparam int SCORE_W = 16;
   localparam int MOVE_W  = 16;
   localparam int DEPTH_W = 8;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 32;

   typedef enum logic {
      CMD_STORE = 1'b0,
      CMD_PROBE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } ctrl_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [SCORE_W-1:0] score;
      logic [MOVE_W-1:0]  move;
      logic [DEPTH_W-1:0] depth;
      logic [KIND_W-1:0]  kind;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } ctrl_status_type;

endpackage

`default_nettype wire

### hw/rtl/dmht_ram.sv
// ----------------------------------------------------------------------------
// dmht_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dmht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/dmht_ctrl.sv
// ----------------------------------------------------------------------------
// dmht_ctrl
// Controller: clearing pass after reset, then read and commit per request.
// ----------------------------------------------------------------------------
`default_nettype none

module dmht_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  dmht_pkg::ctrl_status_type status,
   output dmht_pkg::ctrl_cmd_type    cmd
);

   import dmht_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // The slot has been read; wait until the result register can take the beat.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/dmht_dpath.sv
// ----------------------------------------------------------------------------
// dmht_dpath
// Datapath: slot memory, replacement decision, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmht_dpath #(
   parameter int INDEX_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dmht_pkg::ctrl_cmd_type             cmd,
   output dmht_pkg::ctrl_status_type          status,
   input  logic                               req_command,
   input  logic [dmht_pkg::KEY_W-1:0]         req_key,
   input  logic signed [dmht_pkg::SCORE_W-1:0] req_score,
   input  logic [dmht_pkg::KIND_W-1:0]        req_bound_kind,
   input  logic [dmht_pkg::DEPTH_W-1:0]       req_search_depth,
   input  logic signed [dmht_pkg::MOVE_W-1:0] req_move_code,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic                               rsp_written,
   output logic signed [dmht_pkg::SCORE_W-1:0] rsp_found_score,
   output logic signed [dmht_pkg::MOVE_W-1:0] rsp_found_move,
   output logic [dmht_pkg::DEPTH_W-1:0]       rsp_found_depth,
   output logic [dmht_pkg::KIND_W-1:0]        rsp_found_kind,
   output logic [dmht_pkg::COUNT_W-1:0]       rsp_probe_total,
   output logic [dmht_pkg::COUNT_W-1:0]       rsp_hit_total,
   output logic [dmht_pkg::COUNT_W-1:0]       rsp_collision_total
);

   import dmht_pkg::*;

   localparam int SLOTS = 2 ** INDEX_BITS;

   // Captured request.
   cmd_type     command_ff;
   entry_type   req_entry_ff;

   // Clearing pass.
   logic [INDEX_BITS-1:0] clr_cnt_ff;
   logic [INDEX_BITS-1:0] clr_cnt_in;

   // Statistics counters.
   logic [COUNT_W-1:0] probe_cnt_ff, probe_cnt_in;
   logic [COUNT_W-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0] coll_cnt_ff, coll_cnt_in;

   // Result register.
   logic      rsp_valid_ff, rsp_valid_in;
   logic      hit_ff, written_ff;
   entry_type found_ff;

   // Memory interface.
   entry_type             slot;
   entry_type             wr_data;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;

   logic is_probe;
   logic key_match;
   logic slot_empty;
   logic replace;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         command_ff         <= cmd_type'(req_command);
         req_entry_ff.key   <= req_key;
         req_entry_ff.score <= req_score;
         req_entry_ff.move  <= req_move_code;
         req_entry_ff.depth <= req_search_depth;
         req_entry_ff.kind  <= req_bound_kind;
      end
   end

   assign is_probe   = (command_ff == CMD_PROBE);
   assign key_match  = (slot.key == req_entry_ff.key);
   assign slot_empty = (slot.key == '0);
   assign replace    = slot_empty || key_match || (req_entry_ff.depth >= slot.depth);

   assign wr_en   = cmd.clear_wr || (cmd.commit && !is_probe && replace);
   assign wr_addr = cmd.clear_wr ? clr_cnt_ff : req_entry_ff.key[INDEX_BITS-1:0];
   assign wr_data = cmd.clear_wr ? '0 : req_entry_ff;

   dmht_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.capture),
      .rd_addr (req_key[INDEX_BITS-1:0]),
      .rd_data (slot)
   );

   assign clr_cnt_in = cmd.clear_wr ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_comb begin
      probe_cnt_in = probe_cnt_ff;
      hit_cnt_in   = hit_cnt_ff;
      coll_cnt_in  = coll_cnt_ff;
      if (cmd.commit && is_probe) begin
         probe_cnt_in = probe_cnt_ff + 1'b1;
         if (key_match) begin
            hit_cnt_in = hit_cnt_ff + 1'b1;
         end else if (!slot_empty) begin
            coll_cnt_in = coll_cnt_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         probe_cnt_ff <= '0;
         hit_cnt_ff   <= '0;
         coll_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         probe_cnt_ff <= probe_cnt_in;
         hit_cnt_ff   <= hit_cnt_in;
         coll_cnt_ff  <= coll_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff     <= is_probe && key_match;
         written_ff <= !is_probe && replace;
         found_ff   <= (is_probe && key_match) ? slot : '0;
      end
   end

   assign status.clear_last = (clr_cnt_ff == {INDEX_BITS{1'b1}});
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_written     = written_ff;
   assign rsp_found_score = found_ff.score;
   assign rsp_found_move  = found_ff.move;
   assign rsp_found_depth = found_ff.depth;
   assign rsp_found_kind  = found_ff.kind;
   // The counters only move when a new result is loaded, so they can feed the port directly.
   assign rsp_probe_total     = probe_cnt_ff;
   assign rsp_hit_total       = hit_cnt_ff;
   assign rsp_collision_total = coll_cnt_ff;

endmodule

`default_nettype wire

### hw/rtl/direct_mapped_hash_table_depth_replace_unit.sv
// ----------------------------------------------------------------------------
// direct_mapped_hash_table_depth_replace_unit
// Direct-mapped transposition table with depth-preferred replacement.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid/req_ready    command, key, score, kind, depth, move
//   rsp_      out        rsp_valid/rsp_ready    hit, written, found fields, totals
//
// For each request the slot memory is read in the accept cycle; the decision,
// write-back and result load follow in the lookup state once the output
// register is free. After reset a clearing pass writes every slot to zero, and
// no request is taken until that pass has finished. A stalled result stalls
// only the commit step; the next request is accepted while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module direct_mapped_hash_table_depth_replace_unit #(
   parameter int INDEX_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  logic [dmht_pkg::KEY_W-1:0]          req_key,
   input  logic signed [dmht_pkg::SCORE_W-1:0] req_score,
   input  logic [dmht_pkg::KIND_W-1:0]         req_bound_kind,
   input  logic [dmht_pkg::DEPTH_W-1:0]        req_search_depth,
   input  logic signed [dmht_pkg::MOVE_W-1:0]  req_move_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic                                rsp_written,
   output logic signed [dmht_pkg::SCORE_W-1:0] rsp_found_score,
   output logic signed [dmht_pkg::MOVE_W-1:0]  rsp_found_move,
   output logic [dmht_pkg::DEPTH_W-1:0]        rsp_found_depth,
   output logic [dmht_pkg::KIND_W-1:0]         rsp_found_kind,
   output logic [dmht_pkg::COUNT_W-1:0]        rsp_probe_total,
   output logic [dmht_pkg::COUNT_W-1:0]        rsp_hit_total,
   output logic [dmht_pkg::COUNT_W-1:0]        rsp_collision_total
);

   import dmht_pkg::*;

   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;

   dmht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   dmht_dpath #(
      .INDEX_BITS (INDEX_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (ctrl_cmd),
      .status              (ctrl_status),
      .req_command         (req_command),
      .req_key             (req_key),
      .req_score           (req_score),
      .req_bound_kind      (req_bound_kind),
      .req_search_depth    (req_search_depth),
      .req_move_code       (req_move_code),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_written         (rsp_written),
      .rsp_found_score     (rsp_found_score),
      .rsp_found_move      (rsp_found_move),
      .rsp_found_depth     (rsp_found_depth),
      .rsp_found_kind      (rsp_found_kind),
      .rsp_probe_total     (rsp_probe_total),
      .rsp_hit_total       (rsp_hit_total),
      .rsp_collision_total (rsp_collision_total)
   );

   // A request is never taken while the slot memory is being cleared.
   `DMHT_NEVER(a_no_accept_in_clear, clock, reset, ctrl_cmd.clear_wr && req_ready, "request taken during clearing pass")
   // A captured request is followed by a cycle without a new accept.
   `DMHT_ASSERT(a_capture_blocks, clock, reset, ctrl_cmd.capture |=> !req_ready, "second request accepted before commit")
   // A commit always presents a result beat in the next cycle.
   `DMHT_ASSERT(a_commit_gives_beat, clock, reset, ctrl_cmd.commit |=> rsp_valid, "commit without result beat")
   // A result cannot be both a probe hit and a store write.
   `DMHT_NEVER(a_hit_xor_written, clock, reset, rsp_valid && rsp_hit && rsp_written, "result marked both hit and written")

endmodule

`default_nettype wire

### verif/tb_direct_mapped_hash_table_depth_replace_unit.sv
// ----------------------------------------------------------------------------
// tb_direct_mapped_hash_table_depth_replace_unit
// Self-checking bench for the depth-preferred direct-mapped hash table.
// A clocked driver offers store and probe requests from a backlog. A clocked
// monitor predicts the outcome of every accepted request from a shadow copy of
// the table and its counters, and compares each response beat field by field.
// ----------------------------------------------------------------------------
module tb_direct_mapped_hash_table_depth_replace_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import dmht_pkg::*;

   localparam int INDEX_BITS    = 10;
   localparam int SLOT_COUNT    = 1 << INDEX_BITS;
   localparam int TAG_W         = KEY_W - INDEX_BITS;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int STALL_LIMIT   = 5000;
   localparam int HOLD_AFTER    = 300;
   localparam int HOLD_CYCLES   = 100;
   localparam int CALM_TAIL     = 250;

   typedef struct packed {
      cmd_type             command;
      logic [KEY_W-1:0]    key;
      logic [SCORE_W-1:0]  score;
      logic [KIND_W-1:0]   kind;
      logic [DEPTH_W-1:0]  depth;
      logic [MOVE_W-1:0]   move;
      logic                drain_first;
   } request_type;

   typedef struct packed {
      logic                hit;
      logic                written;
      logic [SCORE_W-1:0]  score;
      logic [MOVE_W-1:0]   move;
      logic [DEPTH_W-1:0]  depth;
      logic [KIND_W-1:0]   kind;
      logic [COUNT_W-1:0]  probes;
      logic [COUNT_W-1:0]  hits;
      logic [COUNT_W-1:0]  collisions;
   } outcome_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_command = 1'b0;
   logic [KEY_W-1:0]           req_key = '0;
   logic signed [SCORE_W-1:0]  req_score = '0;
   logic [KIND_W-1:0]          req_bound_kind = '0;
   logic [DEPTH_W-1:0]         req_search_depth = '0;
   logic signed [MOVE_W-1:0]   req_move_code = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_hit;
   logic                       rsp_written;
   logic signed [SCORE_W-1:0]  rsp_found_score;
   logic signed [MOVE_W-1:0]   rsp_found_move;
   logic [DEPTH_W-1:0]         rsp_found_depth;
   logic [KIND_W-1:0]          rsp_found_kind;
   logic [COUNT_W-1:0]         rsp_probe_total;
   logic [COUNT_W-1:0]         rsp_hit_total;
   logic [COUNT_W-1:0]         rsp_collision_total;

   direct_mapped_hash_table_depth_replace_unit #(
      .INDEX_BITS(INDEX_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_key            (req_key),
      .req_score          (req_score),
      .req_bound_kind     (req_bound_kind),
      .req_search_depth   (req_search_depth),
      .req_move_code      (req_move_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_written        (rsp_written),
      .rsp_found_score    (rsp_found_score),
      .rsp_found_move     (rsp_found_move),
      .rsp_found_depth    (rsp_found_depth),
      .rsp_found_kind     (rsp_found_kind),
      .rsp_probe_total    (rsp_probe_total),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_collision_total(rsp_collision_total)
   );

   always #5 clock = ~clock;

   // Shadow copy of the table and its counters.
   logic [KEY_W-1:0]    shadow_key   [SLOT_COUNT];
   logic [SCORE_W-1:0]  shadow_score [SLOT_COUNT];
   logic [MOVE_W-1:0]   shadow_move  [SLOT_COUNT];
   logic [DEPTH_W-1:0]  shadow_depth [SLOT_COUNT];
   logic [KIND_W-1:0]   shadow_kind  [SLOT_COUNT];
   logic [COUNT_W-1:0]  probes_so_far = '0;
   logic [COUNT_W-1:0]  hits_so_far = '0;
   logic [COUNT_W-1:0]  collisions_so_far = '0;

   request_type  request_backlog [$];
   outcome_type  awaited_outcomes [$];
   logic [KEY_W-1:0] recent_keys [$];
   logic [INDEX_BITS-1:0] slot_pool [8];
   logic [TAG_W-1:0]      tag_pool [4];

   int  failures = 0;
   int  requests_taken = 0;
   int  results_seen = 0;
   int  quiet_cycles = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  hold_left = 0;
   logic hold_done = 1'b0;
   logic req_beat_taken = 1'b0;

   // Applies one request to the shadow table and returns the response it earns.
   function automatic outcome_type table_access_outcome(request_type r);
      outcome_type o;
      logic [INDEX_BITS-1:0] slot;
      o = '0;
      slot = r.key[INDEX_BITS-1:0];
      if (r.command == CMD_STORE) begin
         if (shadow_key[slot] == '0 || shadow_key[slot] == r.key ||
             r.depth >= shadow_depth[slot]) begin
            shadow_key[slot]   = r.key;
            shadow_score[slot] = r.score;
            shadow_move[slot]  = r.move;
            shadow_depth[slot] = r.depth;
            shadow_kind[slot]  = r.kind;
            o.written = 1'b1;
         end
      end else begin
         probes_so_far = probes_so_far + 1'b1;
         if (shadow_key[slot] == r.key) begin
            hits_so_far = hits_so_far + 1'b1;
            o.hit   = 1'b1;
            o.score = shadow_score[slot];
            o.move  = shadow_move[slot];
            o.depth = shadow_depth[slot];
            o.kind  = shadow_kind[slot];
         end else if (shadow_key[slot] != '0) begin
            collisions_so_far = collisions_so_far + 1'b1;
         end
      end
      o.probes     = probes_so_far;
      o.hits       = hits_so_far;
      o.collisions = collisions_so_far;
      return o;
   endfunction

   function automatic request_type make_request(cmd_type c, logic [KEY_W-1:0] k,
                                                logic [SCORE_W-1:0] s, logic [KIND_W-1:0] b,
                                                logic [DEPTH_W-1:0] d, logic [MOVE_W-1:0] m,
                                                logic drain);
      request_type r;
      r.command = c;
      r.key = k;
      r.score = s;
      r.kind = b;
      r.depth = d;
      r.move = m;
      r.drain_first = drain;
      return r;
   endfunction

   // Keys mostly fall on a few slots with a few tags, so that hits, collisions
   // and depth contests are common; others repeat a recent key, are zero or are fully random.
   function automatic logic [KEY_W-1:0] pick_key();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30 && recent_keys.size() != 0)
         return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else if (roll < 75)
         return {tag_pool[$urandom_range(0, 3)], slot_pool[$urandom_range(0, 7)]};
      else if (roll < 78)
         return '0;
      else
         return {$urandom, $urandom};
   endfunction

   function automatic logic [DEPTH_W-1:0] pick_depth();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return DEPTH_W'($urandom_range(0, 7));
      else if (roll < 78)
         return '0;
      else if (roll < 86)
         return '1;
      else
         return DEPTH_W'($urandom);
   endfunction

   function automatic request_type random_request(cmd_type c, logic [KEY_W-1:0] k);
      return make_request(c, k, SCORE_W'($urandom), KIND_W'($urandom), pick_depth(),
                          MOVE_W'($urandom), 1'b0);
   endfunction

   task automatic remember_key(logic [KEY_W-1:0] k);
      recent_keys.push_back(k);
      if (recent_keys.size() > 16)
         void'(recent_keys.pop_front());
   endtask

   task automatic report_if_differs(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         failures++;
      end
   endtask

   // Driver: a new beat is chosen only when the line is free.
   always @(negedge clock) begin : drive_requests
      request_type next_req;
      logic may_idle;
      may_idle = hold_left == 0 && request_backlog.size() > CALM_TAIL &&
                 !(requests_taken >= 700 && requests_taken < 900);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (send_gap != 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (request_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (request_backlog[0].drain_first && awaited_outcomes.size() != 0) begin
            req_valid <= 1'b0;
         end else if (may_idle && $urandom_range(0, 99) < 20) begin
            send_gap <= $urandom_range(0, 6);
            req_valid <= 1'b0;
         end else begin
            next_req = request_backlog.pop_front();
            req_valid        <= 1'b1;
            req_command      <= next_req.command;
            req_key          <= next_req.key;
            req_score        <= next_req.score;
            req_bound_kind   <= next_req.kind;
            req_search_depth <= next_req.depth;
            req_move_code    <= next_req.move;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off so the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (request_backlog.size() > CALM_TAIL &&
                   !(results_seen >= 1100 && results_seen < 1300) &&
                   $urandom_range(0, 99) < 25) begin
         stall_left <= $urandom_range(0, 6);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: checks response beats, then predicts accepted request beats.
   always @(posedge clock) begin : watch_channels
      outcome_type want;
      request_type taken;
      if (reset) begin
         req_beat_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (awaited_outcomes.size() == 0) begin
               $display("%0t ns: response beat with nothing expected, actual hit %0b written %0b",
                        $time, rsp_hit, rsp_written);
               failures++;
            end else begin
               want = awaited_outcomes.pop_front();
               report_if_differs("hit", want.hit, rsp_hit);
               report_if_differs("written", want.written, rsp_written);
               report_if_differs("found_score", want.score, $unsigned(rsp_found_score));
               report_if_differs("found_move", want.move, $unsigned(rsp_found_move));
               report_if_differs("found_depth", want.depth, rsp_found_depth);
               report_if_differs("found_kind", want.kind, rsp_found_kind);
               report_if_differs("probe_total", want.probes, rsp_probe_total);
               report_if_differs("hit_total", want.hits, rsp_hit_total);
               report_if_differs("collision_total", want.collisions, rsp_collision_total);
            end
         end
         if (req_valid && req_ready) begin
            taken = make_request(cmd_type'(req_command), req_key, req_score, req_bound_kind,
                                 req_search_depth, req_move_code, 1'b0);
            awaited_outcomes.push_back(table_access_outcome(taken));
            requests_taken++;
         end
         req_beat_taken <= req_valid && req_ready;
      end
   end

   // Watchdog on cycles without any beat; it also covers the clearing pass.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : run_test
      logic [KEY_W-1:0] key_a, key_b, key_c, key_d, k;
      request_type pair_store;
      int made;
      key_a = 64'h0123_4567_89ab_c005;
      key_b = 64'hfedc_ba98_7654_3005;
      key_c = 64'h0000_0001_0000_0000;
      key_d = 64'h8000_0000_0000_03ff;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         shadow_key[i]   = '0;
         shadow_score[i] = '0;
         shadow_move[i]  = '0;
         shadow_depth[i] = '0;
         shadow_kind[i]  = '0;
      end

      // Directed part: zero-key probes and stores, depth contests, key match,
      // collisions, an emptied slot and the field extremes.
      request_backlog.push_back(make_request(CMD_PROBE, '0, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, key_a, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, key_a, 16'h8000, 2'd3, 8'd10,
                                             16'h7fff, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, key_a, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, key_b, '1, '1, '1, '1, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, key_b, 16'h1111, 2'd1, 8'd9,
                                             16'h2222, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, key_b, 16'h3333, 2'd2, 8'd10,
                                             16'h4444, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, key_a, 16'h5555, 2'd0, 8'd0,
                                             16'h6666, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, key_b, 16'hffff, 2'd3, 8'd0,
                                             16'h0000, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, key_b, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, '0, 16'd1234, 2'd2, 8'd200,
                                             16'hbeef, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, '0, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, key_c, 16'h0042, 2'd1, 8'd5,
                                             16'h0099, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, '0, 16'h7777, 2'd3, 8'd0,
                                             16'h7777, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, '0, 16'h0001, 2'd0, 8'd255,
                                             16'h0002, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, key_c, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, '1, 16'h7fff, 2'd0, 8'd255,
                                             16'h8000, 1'b1));
      request_backlog.push_back(make_request(CMD_STORE, key_d, 16'h0abc, 2'd2, 8'd254,
                                             16'h0def, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, key_d, 16'h1abc, 2'd3, 8'd255,
                                             16'h1def, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, '1, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, key_d, '0, '0, '0, '0, 1'b0));
      request_backlog.push_back(make_request(CMD_STORE, '1, 16'h8000, 2'd1, 8'd255,
                                             16'h7fff, 1'b0));
      request_backlog.push_back(make_request(CMD_PROBE, '1, '0, '0, '0, '0, 1'b0));

      slot_pool[0] = '0;
      slot_pool[1] = '1;
      for (int i = 2; i < 8; i++)
         slot_pool[i] = INDEX_BITS'($urandom);
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      tag_pool[2] = TAG_W'({$urandom, $urandom});
      tag_pool[3] = TAG_W'({$urandom, $urandom});

      // Random part: mostly a store followed by a probe of the same key, mixed
      // with loose stores and probes over a crowded set of slots.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         k = pick_key();
         remember_key(k);
         if ($urandom_range(0, 99) < 45) begin
            pair_store = random_request(CMD_STORE, k);
            pair_store.drain_first = made % 400 == 0;
            request_backlog.push_back(pair_store);
            request_backlog.push_back(random_request(CMD_PROBE, k));
            made += 2;
         end else begin
            request_backlog.push_back(random_request($urandom_range(0, 1) ? CMD_PROBE : CMD_STORE,
                                                     k));
            made++;
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (request_backlog.size() != 0 || req_valid || awaited_outcomes.size() != 0);
      repeat (20) @(posedge clock);

      if (failures == 0 && awaited_outcomes.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/dmht_pkg.sv
hw/rtl/dmht_ram.sv
hw/rtl/dmht_ctrl.sv
hw/rtl/dmht_dpath.sv
hw/rtl/direct_mapped_hash_table_depth_replace_unit.sv
verif/tb_direct_mapped_hash_table_depth_replace_unit.sv
